>>> sv/strict_priority_event_queue_macros.svh
// Assertion macros for the strict priority event queue.
`ifndef STRICT_PRIORITY_EVENT_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_EVENT_QUEUE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on the rising edge of clock outside reset.
`define SPEQ_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPEQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SPEQ_ASSERT_IMPL(label, ante, cons, msg)
`define SPEQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> sv/speq_pkg.sv
// Shared types and default constants of the strict priority event queue.
`timescale 1ns / 1ps

package speq_pkg;

   localparam int DEF_NUM_PRIORITIES = 4;
   localparam int DEF_FIFO_DEPTH     = 16;

   localparam int PRIO_W = 2;

   // operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic [7:0]  module_id;
      logic [7:0]  evt_code;
      logic [7:0]  event_status;
      logic [15:0] payload_length;
   } record_type;

   // control half of a result, from the pointer logic to the output stage
   typedef struct packed {
      logic              strobe;
      logic              record_valid;
      logic              push_dropped;
      logic [PRIO_W-1:0] out_priority;
   } rsp_ctrl_type;

endpackage

>>> sv/speq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module speq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/speq_ctrl.sv
// Per-priority FIFO pointers, fill counts, priority pick and result control.
`timescale 1ns / 1ps
`include "strict_priority_event_queue_macros.svh"

module speq_ctrl #(
   parameter int NUM_PRIORITIES = speq_pkg::DEF_NUM_PRIORITIES,
   parameter int FIFO_DEPTH     = speq_pkg::DEF_FIFO_DEPTH,
   parameter int ADDR_W         = $clog2(NUM_PRIORITIES) + $clog2(FIFO_DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       item_valid,
   input  logic                       operation,
   input  logic [speq_pkg::PRIO_W-1:0] priority_req,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [ADDR_W-1:0]          rd_addr,
   output speq_pkg::rsp_ctrl_type     rsp_ctrl
);

   import speq_pkg::*;

   localparam int LVL_W = $clog2(NUM_PRIORITIES);
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   logic [PTR_W-1:0] wptr_ff  [NUM_PRIORITIES];
   logic [PTR_W-1:0] wptr_in  [NUM_PRIORITIES];
   logic [PTR_W-1:0] rptr_ff  [NUM_PRIORITIES];
   logic [PTR_W-1:0] rptr_in  [NUM_PRIORITIES];
   logic [CNT_W-1:0] count_ff [NUM_PRIORITIES];
   logic [CNT_W-1:0] count_in [NUM_PRIORITIES];

   rsp_ctrl_type rsp_ctrl_ff;
   rsp_ctrl_type rsp_ctrl_in;

   logic [LVL_W-1:0] push_lvl;
   logic [LVL_W-1:0] pop_lvl;
   logic             lvl_ok;
   logic             push_ok;
   logic             dropped;
   logic             found;
   logic             pop_ok;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // priority pick: lowest numbered non-empty FIFO
   always_comb begin
      pop_lvl = '0;
      found   = 1'b0;
      for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            pop_lvl = LVL_W'(i);
            found   = 1'b1;
         end
      end
   end

   assign lvl_ok   = int'(priority_req) < NUM_PRIORITIES;
   assign push_lvl = LVL_W'(priority_req);
   assign push_ok  = item_valid && (operation == OP_PUSH) && lvl_ok
                     && (count_ff[push_lvl] != CNT_FULL);
   assign dropped  = item_valid && (operation == OP_PUSH) && !push_ok;
   assign pop_ok   = item_valid && (operation == OP_POP) && found;

   assign wr_en   = push_ok;
   assign wr_addr = {push_lvl, wptr_ff[push_lvl]};
   assign rd_addr = {pop_lvl, rptr_ff[pop_lvl]};

   always_comb begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
         wptr_in[i]  = wptr_ff[i];
         rptr_in[i]  = rptr_ff[i];
         count_in[i] = count_ff[i];
      end
      if (push_ok) begin
         wptr_in[push_lvl]  = advance(wptr_ff[push_lvl]);
         count_in[push_lvl] = count_ff[push_lvl] + CNT_W'(1);
      end
      if (pop_ok) begin
         rptr_in[pop_lvl]  = advance(rptr_ff[pop_lvl]);
         count_in[pop_lvl] = count_ff[pop_lvl] - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_ctrl_in.strobe       = item_valid;
      rsp_ctrl_in.record_valid = pop_ok;
      rsp_ctrl_in.push_dropped = dropped;
      rsp_ctrl_in.out_priority = pop_ok ? PRIO_W'(pop_lvl) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            wptr_ff[i]  <= '0;
            rptr_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
         rsp_ctrl_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            wptr_ff[i]  <= wptr_in[i];
            rptr_ff[i]  <= rptr_in[i];
            count_ff[i] <= count_in[i];
         end
         rsp_ctrl_ff <= rsp_ctrl_in;
      end
   end

   assign rsp_ctrl = rsp_ctrl_ff;

   `SPEQ_ASSERT_NEXT(a_pop_hit, item_valid && (operation == OP_POP) && found, rsp_ctrl_ff.strobe && rsp_ctrl_ff.record_valid, "pop with a non-empty FIFO gave no record")
   `SPEQ_ASSERT_IMPL(a_flags_need_strobe, !rsp_ctrl_ff.strobe, !rsp_ctrl_ff.record_valid && !rsp_ctrl_ff.push_dropped, "result flag set without strobe")
   `SPEQ_ASSERT_IMPL(a_flags_exclusive, rsp_ctrl_ff.strobe, !(rsp_ctrl_ff.record_valid && rsp_ctrl_ff.push_dropped), "record and drop flagged together")
   `SPEQ_ASSERT_NEXT(a_push_count, push_ok && (push_lvl == '0), count_ff[0] == $past(count_ff[0]) + CNT_W'(1), "accepted push did not raise the fill count")

endmodule

>>> sv/strict_priority_event_queue.sv
// Strict priority event queue: top level with input register and output stage.
`timescale 1ns / 1ps

// One FIFO of event records per priority level, records held in one shared RAM.
// A new command is taken in every cycle (busy stays low); each command gives
// exactly one result, strobed on rsp_strobe for one cycle once the command has
// passed the input register and then the control register and RAM read
// register. A push answers with rsp_push_dropped when its FIFO is full
// or its priority has no FIFO; a pop returns the oldest record of the lowest
// numbered non-empty priority, or rsp_record_valid low when all are empty.
// The receiver cannot stall, so results must be captured on the strobe.
module strict_priority_event_queue #(
   parameter int NUM_PRIORITIES = speq_pkg::DEF_NUM_PRIORITIES,
   parameter int FIFO_DEPTH     = speq_pkg::DEF_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [1:0]  req_priority_req,
   input  logic [7:0]  req_module_id,
   input  logic [7:0]  req_event_type,
   input  logic [7:0]  req_event_status,
   input  logic [15:0] req_payload_length,
   output logic        rsp_strobe,
   output logic        rsp_record_valid,
   output logic        rsp_push_dropped,
   output logic [1:0]  rsp_out_priority,
   output logic [7:0]  rsp_out_module_id,
   output logic [7:0]  rsp_out_event_type,
   output logic [7:0]  rsp_out_event_status,
   output logic [15:0] rsp_out_payload_length
);

   import speq_pkg::*;

   localparam int ADDR_W = $clog2(NUM_PRIORITIES) + $clog2(FIFO_DEPTH);
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int REC_W  = $bits(record_type);

   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_op_ff;
   logic [PRIO_W-1:0] s1_prio_ff;
   record_type        s1_rec_ff;
   record_type        s1_rec_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [REC_W-1:0]  rd_data;
   record_type        rd_rec;
   rsp_ctrl_type      rsp_ctrl;

   assign busy        = 1'b0;
   assign s1_valid_in = start && !busy;

   always_comb begin
      s1_rec_in.module_id      = req_module_id;
      s1_rec_in.evt_code       = req_event_type;
      s1_rec_in.event_status   = req_event_status;
      s1_rec_in.payload_length = req_payload_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_in) begin
         s1_op_ff   <= req_operation;
         s1_prio_ff <= req_priority_req;
         s1_rec_ff  <= s1_rec_in;
      end
   end

   speq_ctrl #(
      .NUM_PRIORITIES (NUM_PRIORITIES),
      .FIFO_DEPTH     (FIFO_DEPTH),
      .ADDR_W         (ADDR_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (s1_valid_ff),
      .operation    (s1_op_ff),
      .priority_req (s1_prio_ff),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .rsp_ctrl     (rsp_ctrl)
   );

   speq_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (s1_rec_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rec = record_type'(rd_data);

   // payload fields read as zero unless a record came out
   assign rsp_strobe             = rsp_ctrl.strobe;
   assign rsp_record_valid       = rsp_ctrl.record_valid;
   assign rsp_push_dropped       = rsp_ctrl.push_dropped;
   assign rsp_out_priority       = rsp_ctrl.out_priority;
   assign rsp_out_module_id      = rsp_ctrl.record_valid ? rd_rec.module_id : '0;
   assign rsp_out_event_type     = rsp_ctrl.record_valid ? rd_rec.evt_code : '0;
   assign rsp_out_event_status   = rsp_ctrl.record_valid ? rd_rec.event_status : '0;
   assign rsp_out_payload_length = rsp_ctrl.record_valid ? rd_rec.payload_length : '0;

endmodule

>>> sim/strict_priority_event_queue_tb.sv
// Self-checking testbench for the strict priority event queue.
`timescale 1ns / 1ps

module strict_priority_event_queue_tb;
   import speq_pkg::*;

   localparam int NUM_LEVELS  = DEF_NUM_PRIORITIES;
   localparam int LEVEL_DEPTH = DEF_FIFO_DEPTH;
   localparam int RAND_CMDS   = 1550;
   localparam int TAIL_START  = 1350;   // no sender idling from here on
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic       op;
      logic [1:0] prio;
      record_type rec;
      int         idle_before;
      bit         drain_first;
   } queue_cmd_type;

   typedef struct packed {
      logic       record_valid;
      logic       push_dropped;
      logic [1:0] prio;
      record_type rec;
   } event_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = OP_PUSH;
   logic [1:0]  req_priority_req = '0;
   logic [7:0]  req_module_id = '0;
   logic [7:0]  req_event_type = '0;
   logic [7:0]  req_event_status = '0;
   logic [15:0] req_payload_length = '0;
   logic        rsp_strobe;
   logic        rsp_record_valid;
   logic        rsp_push_dropped;
   logic [1:0]  rsp_out_priority;
   logic [7:0]  rsp_out_module_id;
   logic [7:0]  rsp_out_event_type;
   logic [7:0]  rsp_out_event_status;
   logic [15:0] rsp_out_payload_length;

   queue_cmd_type pending_cmds[$];
   event_rsp_type due_rsp_q[$];
   record_type    level_fifo[NUM_LEVELS][$];
   bit            xfer_done = 1'b0;
   int            err_count = 0;
   int            cycle_count = 0;

   strict_priority_event_queue i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_operation          (req_operation),
      .req_priority_req       (req_priority_req),
      .req_module_id          (req_module_id),
      .req_event_type         (req_event_type),
      .req_event_status       (req_event_status),
      .req_payload_length     (req_payload_length),
      .rsp_strobe             (rsp_strobe),
      .rsp_record_valid       (rsp_record_valid),
      .rsp_push_dropped       (rsp_push_dropped),
      .rsp_out_priority       (rsp_out_priority),
      .rsp_out_module_id      (rsp_out_module_id),
      .rsp_out_event_type     (rsp_out_event_type),
      .rsp_out_event_status   (rsp_out_event_status),
      .rsp_out_payload_length (rsp_out_payload_length)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Applies one command to the level FIFOs and returns the answer it must get.
   function automatic event_rsp_type predict_event_rsp(logic op, logic [1:0] prio,
                                                       record_type rec);
      event_rsp_type rsp;
      rsp = '0;
      if (op == OP_PUSH) begin
         if (prio >= NUM_LEVELS || level_fifo[prio].size() >= LEVEL_DEPTH)
            rsp.push_dropped = 1'b1;
         else
            level_fifo[prio].push_back(rec);
      end else begin
         for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
            if (level_fifo[lvl].size() != 0) begin
               rsp.record_valid = 1'b1;
               rsp.prio = lvl[1:0];
               rsp.rec = level_fifo[lvl].pop_front();
               break;
            end
         end
      end
      return rsp;
   endfunction

   function automatic void report_error(string what, event_rsp_type exp_rsp,
                                        event_rsp_type act_rsp);
      err_count++;
      if (err_count <= 10)
         $display("%0t %s: exp valid=%b drop=%b prio=%0d mod=%h type=%h st=%h len=%h | act valid=%b drop=%b prio=%0d mod=%h type=%h st=%h len=%h",
                  $time, what,
                  exp_rsp.record_valid, exp_rsp.push_dropped, exp_rsp.prio,
                  exp_rsp.rec.module_id, exp_rsp.rec.evt_code,
                  exp_rsp.rec.event_status, exp_rsp.rec.payload_length,
                  act_rsp.record_valid, act_rsp.push_dropped, act_rsp.prio,
                  act_rsp.rec.module_id, act_rsp.rec.evt_code,
                  act_rsp.rec.event_status, act_rsp.rec.payload_length);
   endfunction

   // monitor: predicts on each command transfer, checks each strobed result
   always @(posedge clock) begin : monitor
      event_rsp_type act_rsp;
      event_rsp_type exp_rsp;
      record_type    in_rec;
      if (reset) begin
         xfer_done = 1'b0;
      end else begin
         xfer_done = start && !busy;
         if (xfer_done) begin
            in_rec = '{req_module_id, req_event_type, req_event_status, req_payload_length};
            due_rsp_q.push_back(predict_event_rsp(req_operation, req_priority_req, in_rec));
         end
         if (rsp_strobe) begin
            act_rsp.record_valid = rsp_record_valid;
            act_rsp.push_dropped = rsp_push_dropped;
            act_rsp.prio = rsp_out_priority;
            act_rsp.rec = '{rsp_out_module_id, rsp_out_event_type, rsp_out_event_status,
                            rsp_out_payload_length};
            if (due_rsp_q.size() == 0) begin
               report_error("unexpected result", '0, act_rsp);
            end else begin
               exp_rsp = due_rsp_q.pop_front();
               if (act_rsp !== exp_rsp)
                  report_error("result mismatch", exp_rsp, act_rsp);
            end
         end
      end
   end

   // driver: holds a command until its transfer, then loads the next one
   always @(negedge clock) begin : driver
      queue_cmd_type cmd;
      if (reset) begin
         start <= 1'b0;
      end else if (start && !xfer_done) begin
         // still waiting for the transfer
      end else if (pending_cmds.size() == 0) begin
         start <= 1'b0;
      end else if (pending_cmds[0].idle_before != 0) begin
         pending_cmds[0].idle_before--;
         start <= 1'b0;
      end else if (pending_cmds[0].drain_first && due_rsp_q.size() != 0) begin
         start <= 1'b0;
      end else begin
         cmd = pending_cmds.pop_front();
         start <= 1'b1;
         req_operation <= cmd.op;
         req_priority_req <= cmd.prio;
         req_module_id <= cmd.rec.module_id;
         req_event_type <= cmd.rec.evt_code;
         req_event_status <= cmd.rec.event_status;
         req_payload_length <= cmd.rec.payload_length;
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_cmd(logic op, logic [1:0] prio, record_type rec, int idle, bit drain);
      queue_cmd_type cmd;
      cmd.op = op;
      cmd.prio = prio;
      cmd.rec = rec;
      cmd.idle_before = idle;
      cmd.drain_first = drain;
      pending_cmds.push_back(cmd);
   endtask

   function automatic record_type random_rec();
      return '{pick_byte(), pick_byte(), pick_byte(), pick_length()};
   endfunction

   initial begin
      int issued;
      int phase;
      int phase_len;
      int push_pct;
      int hot_level;
      bit hot_mode;
      bit idle_on;
      int idle;
      logic op;
      logic [1:0] prio;
      int settle;

      // directed: empty pop, extremes, priority order, one level filled past full
      add_cmd(OP_POP, 2'd0, '0, 0, 1'b0);
      add_cmd(OP_PUSH, 2'd3, '{8'hff, 8'hff, 8'hff, 16'hffff}, 0, 1'b0);
      add_cmd(OP_PUSH, 2'd0, '{8'h00, 8'h00, 8'h00, 16'h0000}, 0, 1'b0);
      add_cmd(OP_PUSH, 2'd1, '{8'ha5, 8'h5a, 8'hc3, 16'h8001}, 0, 1'b0);
      add_cmd(OP_PUSH, 2'd2, '{8'h0f, 8'hf0, 8'h3c, 16'h7ffe}, 0, 1'b0);
      repeat (5) add_cmd(OP_POP, 2'd3, '{8'hff, 8'hff, 8'hff, 16'hffff}, 0, 1'b0);
      repeat (LEVEL_DEPTH + 1) add_cmd(OP_PUSH, 2'd2, random_rec(), 0, 1'b0);

      issued = 0;
      phase = 0;
      while (issued < RAND_CMDS) begin
         phase_len = $urandom_range(30, 110);
         case ($urandom_range(0, 4))
            0: push_pct = 85;
            1: push_pct = 65;
            2: push_pct = 50;
            3: push_pct = 35;
            default: push_pct = 15;
         endcase
         hot_mode = $urandom_range(0, 1);
         hot_level = $urandom_range(0, NUM_LEVELS - 1);
         idle_on = $urandom_range(0, 2) != 0;
         for (int i = 0; i < phase_len && issued < RAND_CMDS; i++) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            if (hot_mode && $urandom_range(0, 4) != 0)
               prio = hot_level[1:0];
            else
               prio = 2'($urandom);
            idle = (issued < TAIL_START && idle_on && $urandom_range(0, 3) == 0) ?
                   $urandom_range(1, 8) : 0;
            // a few phases start only once every result has come back
            add_cmd(op, prio, random_rec(), idle, i == 0 && (phase == 0 || phase == 4 ||
                                                             phase == 11));
            issued++;
         end
         phase++;
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start) @(posedge clock);
      settle = 0;
      while (due_rsp_q.size() != 0 && settle < 1000) begin
         @(posedge clock);
         settle++;
      end
      repeat (8) @(posedge clock);
      while (due_rsp_q.size() != 0)
         report_error("missing result", due_rsp_q.pop_front(), '0);

      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> strict_priority_event_queue.f
+incdir+sv
sv/speq_pkg.sv
sv/speq_ram.sv
sv/speq_ctrl.sv
sv/strict_priority_event_queue.sv
sim/strict_priority_event_queue_tb.sv
